// ===== src/ray_sphere_intersection_assert.svh =====
// Assertion macros for the ray-sphere intersection block.
// Each macro expects clk_i and rst_ni in scope of the module that uses it.
`ifndef RAY_SPHERE_INTERSECTION_ASSERT_SVH
`define RAY_SPHERE_INTERSECTION_ASSERT_SVH

// Same-cycle implication.
`define RSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ray sphere intersection: assertion failed");

// Next-cycle implication.
`define RSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ray sphere intersection: assertion failed");

`endif

// ===== src/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths, constants and the queue entry type shared by the ray-sphere blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  localparam int CoordW  = 32;
  localparam int DirW    = 18;
  localparam int RadW    = 31;
  localparam int DistW   = 31;
  localparam int A0W     = 52;   // magnitude bits of a non-negative projection
  localparam int RemW    = 124;  // squared remainder fed to the root unit
  localparam int RootW   = 62;   // root bits, one per pipeline stage
  localparam int WideW   = 128;  // working width of the Q(4F) comparison
  localparam int QDepth  = 4;
  localparam int QPtrW   = 2;
  localparam int QCntW   = 3;

  localparam logic [DistW-1:0] DistMax = '1;

  typedef struct packed {
    logic             hit;
    logic [A0W-1:0]   a0;
    logic [RemW-1:0]  rem;
  } item_t;

endpackage

`default_nettype wire

// ===== src/rsi_ifs.sv =====
// ----------------------------------------------------------------------------
// rsi_ifs
// Valid/ready channel interfaces for ray-sphere requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsi_ray_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rsi_pkg::CoordW-1:0]    origin_x;
  logic signed [rsi_pkg::CoordW-1:0]    origin_y;
  logic signed [rsi_pkg::CoordW-1:0]    origin_z;
  logic signed [rsi_pkg::DirW-1:0]      dir_x;
  logic signed [rsi_pkg::DirW-1:0]      dir_y;
  logic signed [rsi_pkg::DirW-1:0]      dir_z;
  logic signed [rsi_pkg::CoordW-1:0]    center_x;
  logic signed [rsi_pkg::CoordW-1:0]    center_y;
  logic signed [rsi_pkg::CoordW-1:0]    center_z;
  logic        [rsi_pkg::RadW-1:0]      radius;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, radius, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, radius, output ready);
endinterface

interface rsi_hit_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [rsi_pkg::DistW-1:0]     distance;

  modport source (output valid, hit, distance, input ready);
  modport sink   (input valid, hit, distance, output ready);
endinterface

`default_nettype wire

// ===== src/rsi_front.sv =====
// ----------------------------------------------------------------------------
// rsi_front
// Seven-stage front end: offsets, products, sums and the three miss tests.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  rsi_ray_if.sink             ray_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output rsi_pkg::item_t      item_o
);

  localparam int Sh = 2 * FRAC_BITS;
  localparam int Ws = rsi_pkg::WideW;

  logic        en;
  logic [6:0]  vld_q;

  // Stage 1
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [17:0] vx_q, vy_q, vz_q;
  logic        [30:0] rad_q;
  // Stage 2
  logic        [64:0] sqx_q, sqy_q, sqz_q;
  logic signed [50:0] px_q, py_q, pz_q;
  logic        [61:0] rsq2_q;
  // Stage 3
  logic        [66:0] len2_q;
  logic signed [52:0] a0s_q;
  logic        [61:0] rsq3_q;
  // Stage 4
  logic               inside4_q, neg4_q;
  logic        [51:0] a04_q, pp0_q, pp1_q, pp2_q;
  logic        [66:0] len4_q;
  logic        [61:0] rsq4_q;
  // Stage 5
  logic               miss5_q;
  logic        [51:0] a05_q;
  logic      [Ws-1:0] a2_q, lhs5_q, radsh_q;
  // Stage 6
  logic               miss6_q;
  logic        [51:0] a06_q;
  logic      [Ws-1:0] rhs_q, lhs6_q;
  // Stage 7
  rsi_pkg::item_t     item_q;

  logic signed [65:0] sqx_w, sqy_w, sqz_w;
  logic        [Ws:0] diff_w;

  assign en          = !vld_q[6] || ready_i;
  assign ray_i.ready = en;
  assign valid_o     = vld_q[6];
  assign item_o      = item_q;

  assign sqx_w  = dx_q * dx_q;
  assign sqy_w  = dy_q * dy_q;
  assign sqz_w  = dz_q * dz_q;
  assign diff_w = {1'b0, rhs_q} - {1'b0, lhs6_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[5:0], ray_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= {ray_i.center_x[31], ray_i.center_x} - {ray_i.origin_x[31], ray_i.origin_x};
      dy_q  <= {ray_i.center_y[31], ray_i.center_y} - {ray_i.origin_y[31], ray_i.origin_y};
      dz_q  <= {ray_i.center_z[31], ray_i.center_z} - {ray_i.origin_z[31], ray_i.origin_z};
      vx_q  <= ray_i.dir_x;
      vy_q  <= ray_i.dir_y;
      vz_q  <= ray_i.dir_z;
      rad_q <= ray_i.radius;

      sqx_q  <= sqx_w[64:0];
      sqy_q  <= sqy_w[64:0];
      sqz_q  <= sqz_w[64:0];
      px_q   <= dx_q * vx_q;
      py_q   <= dy_q * vy_q;
      pz_q   <= dz_q * vz_q;
      rsq2_q <= rad_q * rad_q;

      len2_q <= 67'(sqx_q) + 67'(sqy_q) + 67'(sqz_q);
      a0s_q  <= 53'(px_q) + 53'(py_q) + 53'(pz_q);
      rsq3_q <= rsq2_q;

      inside4_q <= len2_q <= 67'(rsq3_q);
      neg4_q    <= a0s_q[52];
      a04_q     <= a0s_q[51:0];
      pp0_q     <= a0s_q[25:0] * a0s_q[25:0];
      pp1_q     <= a0s_q[51:26] * a0s_q[25:0];
      pp2_q     <= a0s_q[51:26] * a0s_q[51:26];
      len4_q    <= len2_q;
      rsq4_q    <= rsq3_q;

      // The cross term appears twice, hence a shift of 27 rather than 26.
      miss5_q <= inside4_q || neg4_q;
      a05_q   <= a04_q;
      a2_q    <= (Ws'(pp2_q) << 52) + (Ws'(pp1_q) << 27) + Ws'(pp0_q);
      lhs5_q  <= Ws'(len4_q) << Sh;
      radsh_q <= Ws'(rsq4_q) << Sh;

      miss6_q <= miss5_q;
      a06_q   <= a05_q;
      rhs_q   <= a2_q + radsh_q;
      lhs6_q  <= lhs5_q;

      item_q.hit <= !miss6_q && !diff_w[Ws];
      item_q.a0  <= a06_q;
      item_q.rem <= diff_w[rsi_pkg::RemW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/rsi_queue.sv =====
// ----------------------------------------------------------------------------
// rsi_queue
// Short register queue that decouples the front end from the root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire rsi_pkg::item_t  push_item_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output rsi_pkg::item_t       pop_item_o
);

  rsi_pkg::item_t                 mem_q [rsi_pkg::QDepth];
  logic [rsi_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [rsi_pkg::QCntW-1:0]      cnt_q;
  logic                           push, pop;

  function automatic logic [rsi_pkg::QCntW-1:0] QCntWExt(input logic b);
    return rsi_pkg::QCntW'(b);
  endfunction

  assign push_ready_o = cnt_q != rsi_pkg::QCntW'(rsi_pkg::QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCntWExt(push) - QCntWExt(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

endmodule

`default_nettype wire

// ===== src/rsi_back.sv =====
// ----------------------------------------------------------------------------
// rsi_back
// Pipelined digit-by-digit square root, then the distance and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 pop_o,
  input  wire rsi_pkg::item_t  item_i,
  rsi_hit_if.source            hit_o
);

  localparam int Rw = rsi_pkg::RootW;
  localparam int Mw = rsi_pkg::RemW;

  logic                        en;
  logic [Rw:0]                 vld_q;
  logic                        hit_q   [Rw+1];
  logic [rsi_pkg::A0W-1:0]     a0_q    [Rw+1];
  logic [Mw-1:0]               rem_q   [Rw+1];
  logic [Rw-1:0]               root_q  [Rw+1];

  logic                        out_vld_q, out_hit_q;
  logic [rsi_pkg::DistW-1:0]   out_dist_q;
  logic [Rw-1:0]               diff_w, shr_w;

  assign en    = !out_vld_q || hit_o.ready;
  assign pop_o = en && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Rw-1:0], valid_i};
      out_vld_q <= vld_q[Rw];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q[0]  <= item_i.hit;
      a0_q[0]   <= item_i.a0;
      rem_q[0]  <= item_i.rem;
      root_q[0] <= '0;
    end
  end

  // Stage k settles root bit Rw-1-k: subtract 2*root*2^b + 4^b when it fits.
  for (genvar k = 0; k < Rw; k++) begin : g_stage
    localparam int B = Rw - 1 - k;
    logic [Mw-1:0] trial;
    logic [Mw:0]   sub;

    assign trial = (Mw'(root_q[k]) << (B + 1)) | (Mw'(1) << (2 * B));
    assign sub   = {1'b0, rem_q[k]} - {1'b0, trial};

    always_ff @(posedge clk_i) begin
      if (en) begin
        hit_q[k+1] <= hit_q[k];
        a0_q[k+1]  <= a0_q[k];
        if (!sub[Mw]) begin
          rem_q[k+1]  <= sub[Mw-1:0];
          root_q[k+1] <= root_q[k] | (Rw'(1) << B);
        end else begin
          rem_q[k+1]  <= rem_q[k];
          root_q[k+1] <= root_q[k];
        end
      end
    end
  end

  assign diff_w = Rw'(a0_q[Rw]) - root_q[Rw];
  assign shr_w  = diff_w >> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= hit_q[Rw];
      if (!hit_q[Rw]) begin
        out_dist_q <= '0;
      end else if (shr_w > Rw'(rsi_pkg::DistMax)) begin
        out_dist_q <= rsi_pkg::DistMax;
      end else begin
        out_dist_q <= shr_w[rsi_pkg::DistW-1:0];
      end
    end
  end

  assign hit_o.valid    = out_vld_q;
  assign hit_o.hit      = out_hit_q;
  assign hit_o.distance = out_dist_q;

endmodule

`default_nettype wire

// ===== src/ray_sphere_intersection.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersection
// Streaming ray-sphere hit test with entry distance in unsigned fixed point.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on ray_i (origin, direction, centre, radius) and one result
// per request leaves on hit_o (hit flag, saturated entry distance, zero on a
// miss). Both channels are valid/ready; a transaction completes when both
// are high at a rising edge.
// Throughput is one transaction per cycle unless the receiver stalls. Each
// request passes seven front-end stages, the queue entry, the square-root input
// register, 62 square-root stages (one root bit each) and the output register.
// Reset clears every pipeline valid bit and empties the queue; no results are
// pending afterwards and the block is ready at once.
// When the receiver stalls, the root pipeline holds, the queue fills, and the
// front end holds in turn; ray_i.ready falls only once all four queue slots
// and the front-end output are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rsi_ray_if.sink     ray_i,
  rsi_hit_if.source   hit_o
);

`include "ray_sphere_intersection_assert.svh"

  logic            f_valid, q_ready, q_valid, b_pop;
  rsi_pkg::item_t  f_item, q_item;

  rsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .ray_i,
    .valid_o (f_valid),
    .ready_i (q_ready),
    .item_o  (f_item)
  );

  rsi_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i (f_valid),
    .push_ready_o (q_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (b_pop),
    .pop_item_o   (q_item)
  );

  rsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i (q_valid),
    .pop_o   (b_pop),
    .item_i  (q_item),
    .hit_o
  );

  `RSI_ASSERT_IMP(a_miss_zero, hit_o.valid && !hit_o.hit, hit_o.distance == '0)
  `RSI_ASSERT_IMP(a_pop_has_data, b_pop, q_valid)
  `RSI_ASSERT_NXT(a_front_holds, f_valid && !q_ready, f_valid)

endmodule

`default_nettype wire
